// File: hw/rtl/sre_pkg.sv
// ---------------------------------------------------------------------------
// sre_pkg: shared types and constants of the S-record stream encoder
// Transaction payloads, record command format and field widths.
// ---------------------------------------------------------------------------
package sre_pkg;

  localparam int BYTE_W           = 8;
  localparam int CHAR_W           = 7;
  localparam int ADDR_W           = 16;
  localparam int LEN_W            = 5;   // data bytes in a record, 0..16
  localparam int FILL_W           = 5;
  localparam int CCNT_W           = 6;   // characters of one input transaction
  localparam int MAX_CHARS        = 63;
  localparam int HDR_W            = 64;
  localparam int HLEN_W           = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int RECORD_BYTES_DEF = 16;
  localparam int CMD_DEPTH        = 2;
  localparam int OUT_DEPTH        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_LEN    = 2'd2;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [1:0] {
    REC_S0 = 2'd0,
    REC_S1 = 2'd1,
    REC_S5 = 2'd2,
    REC_S9 = 2'd3
  } rec_kind_e;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    rec_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              bank;
    logic              first;   // first record of its input transaction
    logic              last;    // last record of its input transaction
  } cmd_t;

  // buffer bank handed back by the record generator
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic int idx_width(int rb);
    return (rb > 1) ? $clog2(rb) : 1;
  endfunction

endpackage

// File: hw/rtl/sre_ram.sv
// ---------------------------------------------------------------------------
// sre_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/sre_fifo.sv
// ---------------------------------------------------------------------------
// sre_fifo: small register FIFO
// Used for the record command queue and the character output queue.
// ---------------------------------------------------------------------------
module sre_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/sre_front.sv
// ---------------------------------------------------------------------------
// sre_front: input side of the S-record encoder
// Accepts transactions, fills the data buffer banks, keeps the file state and
// issues one record command per cycle to the command queue while it has room.
// ---------------------------------------------------------------------------
module sre_front import sre_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  in_item_t                           in_i,
  output logic                               full_o,
  input  logic [HLEN_W-1:0]                  hlen_i,
  input  rel_t                               rel_i,
  input  logic                               cmd_full_i,
  output logic                               cmd_push_o,
  output cmd_t                               cmd_o,
  output logic                               ram_we_o,
  output logic [idx_width(RECORD_BYTES):0]   ram_waddr_o,
  output logic [BYTE_W-1:0]                  ram_wdata_o
);

  localparam int IDX_W = idx_width(RECORD_BYTES);

  // pending record bits, issued lowest first
  localparam int P_S0 = 0;
  localparam int P_S1 = 1;
  localparam int P_S5 = 2;
  localparam int P_S9 = 3;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] rcount_q, rcount_d;
  logic              hdr_sent_q, hdr_sent_d;
  logic              wbank_q, wbank_d;
  logic [1:0]        busy_q, busy_d;
  logic [3:0]        pend_q, pend_d;
  logic              first_q, first_d;
  logic [ADDR_W-1:0] s1_addr_q, s1_addr_d;
  logic [LEN_W-1:0]  s1_len_q, s1_len_d;
  logic              s1_bank_q, s1_bank_d;
  logic [ADDR_W-1:0] s5_addr_q, s5_addr_d;

  logic              accept;
  logic [3:0]        sel;
  logic [FILL_W-1:0] fill_inc;

  assign full_o      = (pend_q != '0) || busy_q[wbank_q];
  assign accept      = push_i && !full_o;
  assign fill_inc    = fill_q + 1'b1;
  assign sel         = pend_q & (~pend_q + 4'd1);
  assign ram_we_o    = accept && (in_i.opcode == OP_DATA);
  assign ram_waddr_o = {wbank_q, fill_q[IDX_W-1:0]};
  assign ram_wdata_o = in_i.data_byte;

  always_comb begin
    cmd_o.addr  = '0;
    cmd_o.len   = '0;
    cmd_o.bank  = 1'b0;
    cmd_o.first = first_q;
    cmd_o.last  = ((pend_q & ~sel) == '0);
    if (sel[P_S0]) begin
      cmd_o.kind = REC_S0;
      cmd_o.len  = LEN_W'(hlen_i);
    end else if (sel[P_S1]) begin
      cmd_o.kind = REC_S1;
      cmd_o.addr = s1_addr_q;
      cmd_o.len  = s1_len_q;
      cmd_o.bank = s1_bank_q;
    end else if (sel[P_S5]) begin
      cmd_o.kind = REC_S5;
      cmd_o.addr = s5_addr_q;
    end else begin
      cmd_o.kind = REC_S9;
    end
  end

  always_comb begin
    fill_d     = fill_q;
    addr_d     = addr_q;
    rcount_d   = rcount_q;
    hdr_sent_d = hdr_sent_q;
    wbank_d    = wbank_q;
    busy_d     = busy_q;
    pend_d     = pend_q;
    first_d    = first_q;
    s1_addr_d  = s1_addr_q;
    s1_len_d   = s1_len_q;
    s1_bank_d  = s1_bank_q;
    s5_addr_d  = s5_addr_q;
    cmd_push_o = 1'b0;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if ((pend_q != '0) && !cmd_full_i) begin
      cmd_push_o = 1'b1;
      pend_d     = pend_q & ~sel;
      first_d    = 1'b0;
    end

    if (accept) begin
      first_d        = 1'b1;
      pend_d         = '0;
      pend_d[P_S0]   = !hdr_sent_q;
      hdr_sent_d     = 1'b1;
      s1_addr_d      = addr_q;
      s1_bank_d      = wbank_q;
      if (in_i.opcode == OP_DATA) begin
        if (fill_inc == FILL_W'(RECORD_BYTES)) begin
          pend_d[P_S1]    = 1'b1;
          s1_len_d        = LEN_W'(fill_inc);
          addr_d          = addr_q + ADDR_W'(RECORD_BYTES);
          rcount_d        = rcount_q + 1'b1;
          fill_d          = '0;
          wbank_d         = !wbank_q;
          busy_d[wbank_q] = 1'b1;
        end else begin
          fill_d = fill_inc;
        end
      end else begin
        pend_d[P_S5] = 1'b1;
        pend_d[P_S9] = 1'b1;
        s5_addr_d    = rcount_q;
        if (fill_q != '0) begin
          // partial record flushed before the trailer
          pend_d[P_S1]    = 1'b1;
          s1_len_d        = LEN_W'(fill_q);
          s5_addr_d       = rcount_q + 1'b1;
          wbank_d         = !wbank_q;
          busy_d[wbank_q] = 1'b1;
        end
        fill_d     = '0;
        addr_d     = '0;
        rcount_d   = '0;
        hdr_sent_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      addr_q     <= '0;
      rcount_q   <= '0;
      hdr_sent_q <= 1'b0;
      wbank_q    <= 1'b0;
      busy_q     <= '0;
      pend_q     <= '0;
      first_q    <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      addr_q     <= addr_d;
      rcount_q   <= rcount_d;
      hdr_sent_q <= hdr_sent_d;
      wbank_q    <= wbank_d;
      busy_q     <= busy_d;
      pend_q     <= pend_d;
      first_q    <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= s1_addr_d;
    s1_len_q  <= s1_len_d;
    s1_bank_q <= s1_bank_d;
    s5_addr_q <= s5_addr_d;
  end

endmodule

// File: hw/rtl/sre_back.sv
// ---------------------------------------------------------------------------
// sre_back: record generator of the S-record encoder
// Turns record commands into ASCII characters, one per cycle when not idle
// or stalled, keeps the checksum, cuts a transaction off after its 63rd char.
// ---------------------------------------------------------------------------
module sre_back import sre_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [HDR_W-1:0]                 hdr_first_i,
  input  logic [HDR_W-1:0]                 hdr_second_i,
  input  logic                             cmd_empty_i,
  input  cmd_t                             cmd_i,
  output logic                             cmd_pop_o,
  output rel_t                             rel_o,
  output logic                             ram_re_o,
  output logic [idx_width(RECORD_BYTES):0] ram_raddr_o,
  input  logic [BYTE_W-1:0]                ram_rdata_i,
  input  logic                             out_full_i,
  output logic                             out_push_o,
  output out_item_t                        out_o
);

  localparam int IDX_W = idx_width(RECORD_BYTES);

  localparam logic [CHAR_W-1:0] CH_S  = 7'h53;
  localparam logic [CHAR_W-1:0] CH_NL = 7'd10;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_HEAD = 5'b00010,
    B_DATA = 5'b00100,
    B_CHK  = 5'b01000,
    B_NL   = 5'b10000
  } bstate_e;

  bstate_e           state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [2:0]        pos_q, pos_d;
  logic [LEN_W-1:0]  bidx_q, bidx_d;
  logic              nib_q, nib_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [CCNT_W-1:0] ccnt_q, ccnt_d;
  logic              skip_q, skip_d;

  logic [2*HDR_W-1:0] hdr_all;
  logic [BYTE_W-1:0]  hdr_byte, cur_byte, cnt_byte, ld_cnt;
  logic [LEN_W-1:0]   bidx_inc;
  logic [CHAR_W-1:0]  ch;
  logic               emit, natural_end, trunc;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (7'h30 + CHAR_W'(n)) : (7'h37 + CHAR_W'(n));
  endfunction

  assign hdr_all  = {hdr_first_i, hdr_second_i};
  assign hdr_byte = hdr_all[2*HDR_W - 1 - BYTE_W*bidx_q[3:0] -: BYTE_W];
  assign cur_byte = (cmd_q.kind == REC_S0) ? hdr_byte : ram_rdata_i;
  assign cnt_byte = BYTE_W'(cmd_q.len) + 8'd3;
  assign ld_cnt   = BYTE_W'(cmd_i.len) + 8'd3;
  assign bidx_inc = bidx_q + 1'b1;

  always_comb begin
    ch = CH_NL;
    unique case (state_q)
      B_HEAD: begin
        case (pos_q)
          3'd0: ch = CH_S;
          3'd1: begin
            unique case (cmd_q.kind)
              REC_S0:  ch = hex_char(4'd0);
              REC_S1:  ch = hex_char(4'd1);
              REC_S5:  ch = hex_char(4'd5);
              default: ch = hex_char(4'd9);
            endcase
          end
          3'd2:    ch = hex_char(cnt_byte[7:4]);
          3'd3:    ch = hex_char(cnt_byte[3:0]);
          3'd4:    ch = hex_char(cmd_q.addr[15:12]);
          3'd5:    ch = hex_char(cmd_q.addr[11:8]);
          3'd6:    ch = hex_char(cmd_q.addr[7:4]);
          default: ch = hex_char(cmd_q.addr[3:0]);
        endcase
      end
      B_DATA:  ch = nib_q ? hex_char(cur_byte[3:0]) : hex_char(cur_byte[7:4]);
      B_CHK:   ch = nib_q ? hex_char(~sum_q[3:0]) : hex_char(~sum_q[7:4]);
      default: ch = CH_NL;
    endcase
  end

  assign emit        = (state_q != B_IDLE) && !out_full_i;
  assign natural_end = (state_q == B_NL) && cmd_q.last;
  assign trunc       = (ccnt_q == CCNT_W'(MAX_CHARS - 1));
  assign out_push_o  = emit;
  assign out_o.out_char    = ch;
  assign out_o.last_of_run = natural_end || trunc;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    bidx_d      = bidx_q;
    nib_d       = nib_q;
    sum_d       = sum_q;
    ccnt_d      = ccnt_q;
    skip_d      = skip_q;
    cmd_pop_o   = 1'b0;
    rel_o       = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {cmd_q.bank, IDX_W'(0)};

    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (skip_q) begin
            // rest of a cut-off transaction: drop and free its bank
            rel_o.valid = (cmd_i.kind == REC_S1);
            rel_o.bank  = cmd_i.bank;
            skip_d      = !cmd_i.last;
          end else begin
            cmd_d   = cmd_i;
            pos_d   = '0;
            sum_d   = ld_cnt + cmd_i.addr[15:8] + cmd_i.addr[7:0];
            ccnt_d  = cmd_i.first ? '0 : ccnt_q;
            state_d = B_HEAD;
          end
        end
      end
      default: begin
        if (emit) begin
          ccnt_d = ccnt_q + 1'b1;
          if (trunc || (state_q == B_NL)) begin
            rel_o.valid = (cmd_q.kind == REC_S1);
            rel_o.bank  = cmd_q.bank;
            skip_d      = trunc && !cmd_q.last && !natural_end;
            state_d     = B_IDLE;
          end else begin
            unique case (state_q)
              B_HEAD: begin
                if (pos_q != 3'd7) begin
                  pos_d = pos_q + 1'b1;
                end else if (cmd_q.len == '0) begin
                  nib_d   = 1'b0;
                  state_d = B_CHK;
                end else begin
                  bidx_d      = '0;
                  nib_d       = 1'b0;
                  ram_re_o    = 1'b1;
                  ram_raddr_o = {cmd_q.bank, IDX_W'(0)};
                  state_d     = B_DATA;
                end
              end
              B_DATA: begin
                if (!nib_q) begin
                  nib_d = 1'b1;
                end else begin
                  sum_d = sum_q + cur_byte;
                  nib_d = 1'b0;
                  if (bidx_inc == cmd_q.len) begin
                    state_d = B_CHK;
                  end else begin
                    bidx_d      = bidx_inc;
                    ram_re_o    = 1'b1;
                    ram_raddr_o = {cmd_q.bank, bidx_inc[IDX_W-1:0]};
                  end
                end
              end
              B_CHK: begin
                if (!nib_q) begin
                  nib_d = 1'b1;
                end else begin
                  state_d = B_NL;
                end
              end
              default: state_d = B_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ccnt_q  <= '0;
      skip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ccnt_q  <= ccnt_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pos_q  <= pos_d;
    bidx_q <= bidx_d;
    nib_q  <= nib_d;
    sum_q  <= sum_d;
  end

endmodule

// File: hw/rtl/srecord_stream_encoder_top.sv
// ---------------------------------------------------------------------------
// srecord_stream_encoder_top: Motorola S-record (S19) stream encoder
// Binary bytes and an end marker in, ASCII S0/S1/S5/S9 record text out.
// ---------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | push / full            | in_i  : opcode, data_byte
//  result   | pop / empty            | out_o : out_char, last_of_run
//  config   | cfg_we_i, cfg_idx_i    | cfg_data_i (64 bits)
//
//  The record generator gives one character per cycle while the character
//  queue has room, and takes each record command from the command queue in
//  its idle state. A data transaction that completes no record and needs no
//  header issues no record command, so it does not hold the input.
//  Stalls: input stalls while the front still issues record commands of the
//  last transaction (one a cycle into a two-deep queue when it has room) or
//  while the buffer bank it would fill is still being read out; two banks
//  let one record fill while the previous one is sent. Output has a two-deep
//  character queue. Reset clears all control state and the configuration
//  registers at once; there is no clearing pass.
//
module srecord_stream_encoder_top import sre_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_i,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HDR_W-1:0]     cfg_data_i
);

  localparam int IDX_W     = idx_width(RECORD_BYTES);
  localparam int RAM_DEPTH = 2 << IDX_W;   // two banks of one record each
  localparam int CMD_W     = $bits(cmd_t);
  localparam int OUT_W     = $bits(out_item_t);

  // configuration registers, written only while the block is idle: the user's rule, unenforced here
  logic [HDR_W-1:0]  hdr_first_q, hdr_second_q;
  logic [HLEN_W-1:0] hlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= '0;
      hdr_second_q <= '0;
      hlen_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HDR_FIRST:  hdr_first_q  <= cfg_data_i;
        CFG_HDR_SECOND: hdr_second_q <= cfg_data_i;
        CFG_HDR_LEN:    hlen_q       <= cfg_data_i[HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // front -> command queue -> back
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t             cmd_wr, cmd_rd;
  logic [CMD_W-1:0] cmd_rd_vec;
  rel_t             rel;

  // data buffer, two banks
  logic              ram_we, ram_re;
  logic [IDX_W:0]    ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  // back -> character queue
  logic             out_push, out_full;
  out_item_t        out_wr;
  logic [OUT_W-1:0] out_rd_vec;

  sre_front #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (in_i),
    .full_o      (full),
    .hlen_i      (hlen_q),
    .rel_i       (rel),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wr),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  sre_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RAM_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sre_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd_vec),
    .empty_o (cmd_empty)
  );

  assign cmd_rd = cmd_t'(cmd_rd_vec);

  sre_back #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hdr_first_i  (hdr_first_q),
    .hdr_second_i (hdr_second_q),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_rd),
    .cmd_pop_o    (cmd_pop),
    .rel_o        (rel),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_o        (out_wr)
  );

  sre_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rd_vec),
    .empty_o (empty)
  );

  assign out_o = out_item_t'(out_rd_vec);

endmodule

// File: bench/srecord_stream_encoder_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srecord_stream_encoder_top_test: self-checking bench for the S19 encoder
// Drives byte and end-marker transactions through the push/full port, rebuilds
// the expected S0/S1/S5/S9 text per transaction and compares every character
// popped from the result port, under several header settings and idle mixes.
// ---------------------------------------------------------------------------
module srecord_stream_encoder_top_test;
  import sre_pkg::*;

  localparam int REC_BYTES = RECORD_BYTES_DEF;

  // -------------------------------------------------------------------------
  // Expected record text. Holds the file state and header registers of the
  // encoder and turns each accepted transaction into the characters it owes.
  // -------------------------------------------------------------------------
  class srec_text;
    logic [127:0]     rec_data;      // byte i at bits 127-8i
    int unsigned      fill;
    logic [15:0]      next_addr;
    logic [15:0]      rec_total;
    bit               header_done;
    logic [63:0]      hdr_first;
    logic [63:0]      hdr_second;
    logic [3:0]       hdr_len;
    logic [7:0]       line_chars[$];
    out_item_t        chars_due[$];
    int unsigned      errors;
    int unsigned      items_taken;
    int unsigned      chars_seen;
    int unsigned      data_records;
    int unsigned      files_closed;

    function new();
      rec_data     = '0;
      fill         = 0;
      next_addr    = '0;
      rec_total    = '0;
      header_done  = 1'b0;
      hdr_first    = '0;
      hdr_second   = '0;
      hdr_len      = '0;
      errors       = 0;
      items_taken  = 0;
      chars_seen   = 0;
      data_records = 0;
      files_closed = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [HDR_W-1:0] value);
      case (idx)
        CFG_HDR_FIRST:  hdr_first  = value;
        CFG_HDR_SECOND: hdr_second = value;
        CFG_HDR_LEN:    hdr_len    = value[3:0];
        default: ;
      endcase
    endfunction

    function void put_hex(logic [7:0] b);
      logic [3:0] nib;
      nib = b[7:4];
      line_chars.push_back((nib < 4'd10) ? ("0" + 8'(nib)) : ("A" + 8'(nib) - 8'd10));
      nib = b[3:0];
      line_chars.push_back((nib < 4'd10) ? ("0" + 8'(nib)) : ("A" + 8'(nib) - 8'd10));
    endfunction

    // 'S', type, count, address, data, checksum, newline
    function void put_record(logic [7:0] kind, logic [15:0] addr, int unsigned len,
                             logic [127:0] data);
      logic [7:0]  cnt;
      logic [7:0]  b;
      logic [31:0] sum;
      cnt = 8'(3 + len);
      sum = 32'(cnt) + 32'(addr[15:8]) + 32'(addr[7:0]);
      line_chars.push_back("S");
      line_chars.push_back(kind);
      put_hex(cnt);
      put_hex(addr[15:8]);
      put_hex(addr[7:0]);
      for (int i = 0; i < len; i++) begin
        b = data[127 - 8*i -: 8];
        put_hex(b);
        sum += 32'(b);
      end
      put_hex(~sum[7:0]);
      line_chars.push_back(8'd10);
    endfunction

    function void flush_data_record();
      put_record("1", next_addr, fill, rec_data);
      next_addr += 16'(REC_BYTES);
      rec_total += 16'd1;
      fill = 0;
      data_records++;
    endfunction

    // accepted input transaction
    function void encode_item(in_item_t it);
      out_item_t c;
      line_chars.delete();
      items_taken++;
      if (!header_done) begin
        put_record("0", 16'h0000, int'(hdr_len), {hdr_first, hdr_second});
        header_done = 1'b1;
      end
      if (it.opcode == OP_DATA) begin
        rec_data[127 - 8*fill -: 8] = it.data_byte;
        fill++;
        if (fill >= REC_BYTES) flush_data_record();
      end else begin
        if (fill > 0) flush_data_record();
        put_record("5", rec_total, 0, '0);
        put_record("9", 16'h0000, 0, '0);
        fill        = 0;
        next_addr   = '0;
        rec_total   = '0;
        header_done = 1'b0;
        files_closed++;
      end
      foreach (line_chars[k]) begin
        c.out_char    = line_chars[k][CHAR_W-1:0];
        c.last_of_run = (k == line_chars.size() - 1);
        chars_due.push_back(c);
      end
    endfunction

    // accepted result transaction
    function void check_char(out_item_t got);
      out_item_t want;
      chars_seen++;
      if (chars_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected char %02h last %0b, nothing outstanding",
                   $realtime, got.out_char, got.last_of_run);
        return;
      end
      want = chars_due.pop_front();
      if (got.out_char !== want.out_char || got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch char exp %02h got %02h, last exp %0b got %0b",
                   $realtime, want.out_char, got.out_char, want.last_of_run,
                   got.last_of_run);
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Block hookup
  // -------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  in_item_t             in_i;
  logic                 empty;
  logic                 pop;
  out_item_t            out_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [HDR_W-1:0]     cfg_data_i;

  srecord_stream_encoder_top #(
    .RECORD_BYTES(REC_BYTES)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_i      (in_i),
    .empty     (empty),
    .pop       (pop),
    .out_o     (out_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  srec_text srec = new();

  int send_idle_pct = 0;   // chance per cycle that the sender holds push low
  int rx_idle_pct   = 0;   // chance per cycle that the receiver holds pop low
  int rx_hold_req   = 0;   // long receiver hold-off, picked up by the receiver

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // reset held low from time zero, released on a falling edge, never asserted again
  initial begin
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // safety net: well beyond the slowest legal run
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: random pop at the falling edge, check at the rising edge. A hold
  // request parks pop low for as long as it asks, counted here.
  // -------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
        pop <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk_i);
        if (pop && !empty) srec.check_char(out_o);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender side tasks; all called and returning on a falling edge
  // -------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    srec.encode_item(it);
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.opcode    = OP_DATA;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_end();
    in_item_t it;
    it.opcode    = OP_END;
    it.data_byte = 8'($urandom);   // ignored by the block
    send_item(it);
  endtask

  // mostly data with the odd end marker, so files of varied length close
  task automatic send_random(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.opcode    = ($urandom_range(19) == 0) ? OP_END : OP_DATA;
      it.data_byte = 8'($urandom);
      send_item(it);
    end
  endtask

  // write enable stays high across back-to-back writes; caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HDR_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    srec.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic write_header(input logic [63:0] first, input logic [63:0] second,
                              input logic [3:0] len);
    write_reg(CFG_HDR_FIRST, first);
    write_reg(CFG_HDR_SECOND, second);
    write_reg(CFG_HDR_LEN, {60'b0, len});
    cfg_we_i <= 1'b0;
  endtask

  // all results in, then room for a record still being built from silent items
  task automatic settle();
    push <= 1'b0;
    while (srec.chars_due.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    push       = 1'b0;
    in_i       = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_HDR_FIRST;
    cfg_data_i = '0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // empty file with an empty header: S0, S5 0000, S9 only
    write_header(64'h0, 64'h0, 4'd0);
    send_end();
    settle();

    // widest header, all ones, including the unused last byte
    write_header('1, '1, 4'd15);
    // one full record with byte extremes, then end with nothing buffered
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(8'h55);
    send_byte(8'hAA);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom));
    send_end();
    // short file: partial S1 at the end marker
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'($urandom));
    send_end();
    settle();

    // sender mostly busy, receiver slow; long receiver hold part-way through
    send_idle_pct = 10;
    rx_idle_pct   = 52;
    write_header({$urandom, $urandom}, {$urandom, $urandom}, 4'($urandom_range(15)));
    send_random(10);
    rx_hold_req = 400;
    send_random(35);
    settle();

    // roles swapped; one-byte header
    send_idle_pct = 52;
    rx_idle_pct   = 10;
    write_header(64'h0, {$urandom, $urandom}, 4'd1);
    send_random(45);
    settle();

    // back to back
    send_idle_pct = 0;
    rx_idle_pct   = 0;
    write_header({$urandom, $urandom}, {$urandom, $urandom}, 4'($urandom_range(15)));
    send_random(18);
    send_end();
    settle();

    $display("Covered %0d transactions in, %0d characters out, %0d S1 records, %0d files.",
             srec.items_taken, srec.chars_seen, srec.data_records, srec.files_closed);
    $display("Header lengths 0, 1, 15 and random; empty, partial and full records; %s",
             "long output hold-off.");
    if (srec.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total", srec.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
